[rtl/mcbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mcbs_pkg;
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_LEN    = 2'd1;
   localparam logic [1:0] CSR_BLOCKS = 2'd2;

   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

   // sinc series coefficients, 32 fraction bits
   function automatic logic [32:0] sin_coef(input logic [2:0] k);
      case (k)
         3'd0: sin_coef = 33'd6746518852;
         3'd1: sin_coef = 33'd2774394673;
         3'd2: sin_coef = 33'd342277223;
         3'd3: sin_coef = 33'd20107981;
         3'd4: sin_coef = 33'd689090;
         3'd5: sin_coef = 33'd15457;
         3'd6: sin_coef = 33'd244;
         default: sin_coef = 33'd3;
      endcase
   endfunction

   // queue entry from front to back
   typedef struct packed {
      logic        clear;
      logic        mode;
      logic [32:0] t;
   } work_type;
endpackage
`default_nettype wire

[rtl/mcbs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Accepts words, forms t = 1-u and pushes into a two-entry queue.
module mcbs_front import mcbs_pkg::*; #(
   parameter int DRAW_BITS = 32
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [31:0] req_tdata,
   input  wire        req_tuser,
   input  wire        mode,
   output logic       q_valid,
   input  wire        q_pop,
   output work_type   q_head
);
   localparam logic [31:0] DRAW_MASK = 32'hFFFF_FFFF << (32 - DRAW_BITS);
   work_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   work_type   w;

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_head = mem_ff[rp_ff];

   always_comb begin
      w.clear = (req_tuser == KIND_CLEAR);
      w.mode = mode;
      w.t = 33'h1_0000_0000 - {1'b0, req_tdata & DRAW_MASK};
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = (q_pop && q_valid) ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= w;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

[rtl/mcbs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: integrand by Horner steps, accumulation, and at block end the
// divides and square root bit-serially.
module mcbs_back import mcbs_pkg::*; #(
   parameter int MAX_BLOCKS      = 1024,
   parameter int MAX_BLOCK_LEN   = 1048576,
   parameter int VALUE_FRAC_BITS = 30
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        q_valid,
   output logic       q_pop,
   input  work_type   q_head,
   input  wire [20:0] samples_per_block,
   input  wire [10:0] block_count,
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [95:0] rsp_tdata,
   output logic       rsp_tlast
);
   localparam int F = VALUE_FRAC_BITS;
   localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_POLY = 4'd2, S_TS = 4'd3,
      S_VAL = 4'd4, S_BM = 4'd5, S_MSQ = 4'd6, S_MEAN = 4'd7, S_MEAN2 = 4'd8,
      S_MM = 4'd9, S_EDIV = 4'd10, S_SQRT = 4'd11, S_OUT = 4'd12;

   logic [3:0]  st_ff, st_in;
   logic [51:0] acc_ff, acc_in;
   logic [20:0] nin_ff, nin_in;
   logic [16:0] blk_ff, blk_in;
   logic [41:0] sm_ff, sm_in;
   logic [43:0] sq_ff, sq_in;
   logic        fin_ff, fin_in;
   logic        md_ff, md_in;
   logic [32:0] t_ff, t_in;
   logic [30:0] s_ff, s_in;
   logic [32:0] h_ff, h_in;
   logic [2:0]  k_ff, k_in;
   logic [63:0] p_ff, p_in;
   // shared restoring divider / isqrt registers
   logic [63:0] num_ff, num_in, q_ff, q_in, rem_ff, rem_in;
   logic [6:0]  bit_ff, bit_in;
   logic [32:0] m_ff, m_in;
   logic [63:0] mean_ff, mean_in;
   logic [63:0] mean2_ff, mean2_in;
   logic        ov_ff, ov_in;
   logic [30:0] cnt_ff, cnt_in;
   logic [31:0] err_ff, err_in;
   logic        last_ff, last_in;
   logic        vo_ff, vo_in;

   logic [20:0] len;
   logic [16:0] nblk;
   logic [63:0] prod, trial, dsor;
   logic [65:0] rtry;

   always_comb begin
      len = (samples_per_block == 21'd0) ? 21'd1 :
            (32'(samples_per_block) > 32'(MAX_BLOCK_LEN)) ? 21'(MAX_BLOCK_LEN) :
            samples_per_block;
      nblk = (block_count == 11'd0) ? 17'd1 :
             ({6'd0, block_count} > 17'(MAX_BLOCKS)) ? 17'(MAX_BLOCKS) :
             {6'd0, block_count};
   end

   always_comb begin
      st_in = st_ff; acc_in = acc_ff; nin_in = nin_ff; blk_in = blk_ff;
      sm_in = sm_ff; sq_in = sq_ff; fin_in = fin_ff; md_in = md_ff;
      t_in = t_ff; s_in = s_ff; h_in = h_ff; k_in = k_ff; p_in = p_ff;
      num_in = num_ff; q_in = q_ff; rem_in = rem_ff; bit_in = bit_ff;
      m_in = m_ff; mean_in = mean_ff; mean2_in = mean2_ff; ov_in = ov_ff;
      cnt_in = cnt_ff; err_in = err_ff; last_in = last_ff;
      vo_in = vo_ff; q_pop = 1'b0;
      prod = '0; trial = '0; rtry = '0; dsor = '0;
      if (vo_ff && rsp_tready) vo_in = 1'b0;
      // one divider step: rem:num / dsor
      unique case (st_ff)
         S_BM:    dsor = {43'd0, nin_ff};
         S_MEAN, S_MEAN2: dsor = {47'd0, blk_ff};
         default: dsor = {47'd0, blk_ff - 17'd1};
      endcase
      trial = {rem_ff[62:0], num_ff[63]};
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid && !vo_ff) begin
               q_pop = 1'b1;
               if (q_head.clear) begin
                  acc_in = '0; nin_in = '0; blk_in = '0; sm_in = '0;
                  sq_in = '0; fin_in = 1'b0;
               end else if (!fin_ff) begin
                  md_in = q_head.mode; t_in = q_head.t; st_in = S_SQ;
               end
            end
         end
         S_SQ: begin
            if (md_ff) s_in = 31'(t_ff >> 2);
            else if (t_ff[32]) s_in = 31'h4000_0000;
            else begin
               prod = t_ff[31:0] * t_ff[31:0];
               s_in = 31'(prod >> 34);
            end
            h_in = sin_coef(3'd7); k_in = 3'd6; st_in = S_POLY;
         end
         S_POLY: begin
            prod = 64'(h_ff) * {33'd0, s_ff};
            p_in = prod >> 30;
            h_in = (p_in > {31'd0, sin_coef(k_ff)}) ? 33'd0 :
                   33'({31'd0, sin_coef(k_ff)} - p_in);
            k_in = k_ff - 3'd1;
            if (k_ff == 3'd0) st_in = md_ff ? S_VAL : S_TS;
         end
         S_TS: begin
            prod = 64'(t_ff >> 1) * 64'(h_ff);
            h_in = 33'(prod >> 31); st_in = S_VAL;
         end
         S_VAL: begin
            prod = {32'd0, HALF_PI_Q30} * 64'(h_ff);
            prod = md_ff ? (prod >> (63 - F)) : (prod >> (62 - F));
            acc_in = acc_ff + 52'(prod);
            nin_in = nin_ff + 21'd1;
            st_in = S_IDLE;
            if (nin_in >= len) begin
               num_in = {12'd0, acc_in}; rem_in = '0; q_in = '0;
               bit_in = 7'd64; st_in = S_BM;
            end
         end
         S_BM, S_MEAN, S_MEAN2, S_EDIV: begin
            if (bit_ff != 7'd0) begin
               num_in = {num_ff[62:0], 1'b0};
               if (trial >= dsor) begin
                  rem_in = trial - dsor; q_in = {q_ff[62:0], 1'b1};
               end else begin
                  rem_in = trial; q_in = {q_ff[62:0], 1'b0};
               end
               bit_in = bit_ff - 7'd1;
            end else begin
               rem_in = '0; bit_in = 7'd64; q_in = '0;
               unique case (st_ff)
                  S_BM: begin
                     m_in = 33'(q_ff);
                     acc_in = '0; nin_in = '0; blk_in = blk_ff + 17'd1;
                     st_in = S_MSQ;
                  end
                  S_MEAN: begin
                     mean_in = q_ff; num_in = {20'd0, sq_ff};
                     st_in = S_MEAN2;
                  end
                  S_MEAN2: begin
                     mean2_in = q_ff; st_in = S_MM;
                  end
                  default: begin
                     num_in = '0; rem_in = '0;
                     p_in = 64'(q_ff << F); bit_in = 7'd32;
                     st_in = S_SQRT;
                  end
               endcase
            end
         end
         S_MSQ: begin
            prod = 64'(m_ff) * 64'(m_ff);
            sm_in = sm_ff + 42'(m_ff);
            sq_in = sq_ff + 44'(prod >> F);
            num_in = {22'd0, sm_in};
            st_in = S_MEAN;
         end
         S_MM: begin
            ov_in = (mean_ff[63:32] != 32'd0);
            prod = mean_ff[31:0] * mean_ff[31:0];
            p_in = prod >> F;
            err_in = '0;
            if (blk_ff > 17'd1 && !ov_in && mean2_ff > p_in) begin
               num_in = mean2_ff - p_in; st_in = S_EDIV;
            end else st_in = S_OUT;
         end
         S_SQRT: begin
            // digit-by-digit root of p_ff, two bits a step
            if (bit_ff != 7'd0) begin
               rtry = {rem_ff, p_ff[63:62]} - {q_ff, 2'b01};
               if (!rtry[65]) begin
                  rem_in = rtry[63:0]; q_in = {q_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[61:0], p_ff[63:62]}; q_in = {q_ff[62:0], 1'b0};
               end
               p_in = {p_ff[61:0], 2'b00};
               bit_in = bit_ff - 7'd1;
            end else begin
               err_in = q_ff[31:0]; st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!vo_ff) begin
               last_in = (blk_ff >= nblk);
               fin_in = last_in;
               cnt_in = 31'(64'(blk_ff) * 64'(len));
               vo_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      md_ff <= md_in; t_ff <= t_in; s_ff <= s_in; h_ff <= h_in; k_ff <= k_in;
      p_ff <= p_in; num_ff <= num_in; q_ff <= q_in; rem_ff <= rem_in;
      bit_ff <= bit_in; m_ff <= m_in; mean_ff <= mean_in; mean2_ff <= mean2_in;
      ov_ff <= ov_in; cnt_ff <= cnt_in; err_ff <= err_in; last_ff <= last_in;
      if (reset) begin
         st_ff <= S_IDLE; acc_ff <= '0; nin_ff <= '0; blk_ff <= '0;
         sm_ff <= '0; sq_ff <= '0; fin_ff <= 1'b0; vo_ff <= 1'b0;
      end else begin
         st_ff <= st_in; acc_ff <= acc_in; nin_ff <= nin_in; blk_ff <= blk_in;
         sm_ff <= sm_in; sq_ff <= sq_in; fin_ff <= fin_in; vo_ff <= vo_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata = {1'b0, err_ff, mean_ff[31:0], cnt_ff};
   assign rsp_tlast = last_ff;
endmodule
`default_nettype wire

[rtl/monte_carlo_block_statistics_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Monte Carlo blocking-method statistics.
// req_: one word per draw; tuser is the kind (0 sample, 1 clear), tdata the
// uniform draw in Q0.32. rsp_: one word per finished block; tdata carries
// sample count, running mean and error (Q2.30), tlast marks the run's end.
// csr_: write port, index 0 mode, 1 block length, 2 blocks per run.
// A two-word queue parts the input stage from a sequencer. A sample passes
// through the sequencer as pop, square (a shift in importance mode), seven
// Horner steps on one multiplier, a multiply by t (skipped in importance
// mode) and scaling. A block end adds four bit-serial divisions, a bit-serial
// square root and three single steps; the error's division and root are
// skipped when the error is zero. A clear or ignored sample is only popped.
// Reset (synchronous) empties the queue, clears the statistics and loads the
// register defaults. While rsp_tready is low the result is held and the
// sequencer waits; the queue still takes up to two words.
module monte_carlo_block_statistics_unit import mcbs_pkg::*; #(
   parameter int MAX_BLOCKS      = 1024,
   parameter int MAX_BLOCK_LEN   = 1048576,
   parameter int DRAW_BITS       = 32,
   parameter int VALUE_FRAC_BITS = 30
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,  // uniform_draw
   input  wire         req_tuser,  // kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [95:0] rsp_tdata,  // samples_so_far[30:0], running_mean, running_error, pad
   output logic        rsp_tlast,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [20:0] csr_wdata
);
   logic        mode_ff;
   logic [20:0] len_ff;
   logic [10:0] nblk_ff;
   logic        q_valid, q_pop;
   work_type    q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; len_ff <= 21'd10000; nblk_ff <= 11'd100;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff <= csr_wdata[0];
            CSR_LEN:    len_ff <= csr_wdata;
            CSR_BLOCKS: nblk_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   mcbs_front #(.DRAW_BITS(DRAW_BITS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .mode(mode_ff), .q_valid, .q_pop, .q_head);

   mcbs_back #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_BLOCK_LEN(MAX_BLOCK_LEN),
      .VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_head,
      .samples_per_block(len_ff), .block_count(nblk_ff),
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast);
endmodule
`default_nettype wire

[rtl/mcbs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcbs_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [95:0] rsp_tdata,
   input wire        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result dropped under stall");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[30:0] != 31'd0)
      else $error("zero sample count");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[95])
      else $error("pad bit set");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule
bind monte_carlo_block_statistics_unit mcbs_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast);
`default_nettype wire
